// File: hw/rtl/sign_region_peak_detector_top_assert.svh
// assertion helpers for the sign region peak detector
`ifndef SIGN_REGION_PEAK_DETECTOR_TOP_ASSERT_SVH
`define SIGN_REGION_PEAK_DETECTOR_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SRPD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define SRPD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/srpd_pkg.sv
package srpd_pkg;

  localparam int CHANNELS    = 8;
  localparam int SAMPLE_BITS = 16;
  localparam int CH_W        = 3;
  localparam int POS_W       = 32;
  localparam int PEAK_W      = SAMPLE_BITS;
  localparam int OFF_W       = SAMPLE_BITS + 1;
  localparam int RATIO_W     = 17;
  localparam int SIGN_W      = 2;
  localparam int CFG_AW      = 3;
  localparam int CFG_DW      = 32;

  localparam logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(65536);

  localparam logic [SIGN_W-1:0] SIGN_NEG  = 2'd0;
  localparam logic [SIGN_W-1:0] SIGN_ZERO = 2'd1;
  localparam logic [SIGN_W-1:0] SIGN_POS  = 2'd2;

  localparam logic REG_TOL = 1'b0;
  localparam logic REG_ABS = 1'b1;

  typedef struct packed {
    logic [POS_W-1:0]        pos;
    logic [SIGN_W-1:0]       sign;
    logic [POS_W-1:0]        start;
    logic [PEAK_W-1:0]       peak;
    logic [POS_W-1:0]        peak_pos;
    logic signed [OFF_W-1:0] offset;
  } rec_t;

  localparam rec_t REC_RESET = '{
    pos: '0, sign: SIGN_ZERO, start: '0, peak: '0, peak_pos: '0, offset: '0
  };

  typedef struct packed {
    logic [CH_W-1:0]   out_channel;
    logic [SIGN_W-1:0] region_sign;
    logic [POS_W-1:0]  region_start;
    logic [POS_W-1:0]  region_end;
    logic [PEAK_W-1:0] peak_magnitude;
    logic [POS_W-1:0]  peak_position;
    logic              last_of_run;
  } result_t;

endpackage

// File: hw/rtl/srpd_if.sv
interface srpd_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [srpd_pkg::CH_W-1:0]            channel;
  logic signed [srpd_pkg::SAMPLE_BITS-1:0] sample;
  logic                                 end_of_stream;

  modport source (output valid, channel, sample, end_of_stream, input ready);
  modport sink   (input valid, channel, sample, end_of_stream, output ready);
endinterface

interface srpd_out_if;
  logic                            valid;
  logic                            ready;
  logic [srpd_pkg::CH_W-1:0]       out_channel;
  logic [srpd_pkg::SIGN_W-1:0]     region_sign;
  logic [srpd_pkg::POS_W-1:0]      region_start;
  logic [srpd_pkg::POS_W-1:0]      region_end;
  logic [srpd_pkg::PEAK_W-1:0]     peak_magnitude;
  logic [srpd_pkg::POS_W-1:0]      peak_position;
  logic                            last_of_run;

  modport source (output valid, out_channel, region_sign, region_start, region_end,
                  peak_magnitude, peak_position, last_of_run, input ready);
  modport sink   (input valid, out_channel, region_sign, region_start, region_end,
                  peak_magnitude, peak_position, last_of_run, output ready);
endinterface

// File: hw/rtl/srpd_offset.sv
// hysteresis offset magnitude: floor((a*FS + peak*(1-a)) * t / 2^32)
// first product registered, second product feeds the caller directly
module srpd_offset (
  input  logic                                clk,
  input  logic                                load,
  input  logic [srpd_pkg::RATIO_W-1:0]        tol,
  input  logic [srpd_pkg::RATIO_W-1:0]        abs_ratio,
  input  logic [srpd_pkg::PEAK_W-1:0]         peak,
  output logic [srpd_pkg::OFF_W-1:0]          mag
);

  localparam int INNER_W = 32;
  localparam int BLEND_W = srpd_pkg::PEAK_W + srpd_pkg::RATIO_W;
  localparam int PROD_W  = INNER_W + srpd_pkg::RATIO_W;

  logic [srpd_pkg::RATIO_W-1:0] t_sat;
  logic [srpd_pkg::RATIO_W-1:0] a_sat;
  logic [srpd_pkg::RATIO_W-1:0] a_inv;
  logic [BLEND_W-1:0]           blend;
  logic [BLEND_W-1:0]           full;
  logic [BLEND_W-1:0]           inner;
  logic [INNER_W-1:0]           inner_r;
  logic [PROD_W-1:0]            prod;

  // ratios above one saturate to one
  assign t_sat = (tol > srpd_pkg::RATIO_ONE) ? srpd_pkg::RATIO_ONE : tol;
  assign a_sat = (abs_ratio > srpd_pkg::RATIO_ONE) ? srpd_pkg::RATIO_ONE : abs_ratio;
  assign a_inv = srpd_pkg::RATIO_ONE - a_sat;

  assign blend = BLEND_W'(peak) * BLEND_W'(a_inv);
  assign full  = BLEND_W'(a_sat) << (srpd_pkg::SAMPLE_BITS - 1);
  assign inner = blend + full;

  always_ff @(posedge clk) begin
    if (load) begin
      inner_r <= inner[INNER_W-1:0];
    end
  end

  assign prod = PROD_W'(inner_r) * PROD_W'(t_sat);
  assign mag  = prod[PROD_W-1 -: srpd_pkg::OFF_W];

endmodule

// File: hw/rtl/sign_region_peak_detector_top.sv
// sign region peak detector
// in_ch carries one audio sample per transaction: channel, signed sample and an
// end-of-stream flag. out_ch carries closed regions: sign, start, end, peak and
// peak position, with last_of_run marking the final region of one sample.
// a sample yields zero, one or two regions. the APB port sets the tolerance
// (address 0) and absoluteness (address 4) ratios and must only be written
// while the block is idle.
// per-channel state sits in a single record memory with a registered read.
// each sample goes through memory read, region update with the first offset
// multiply, then the second multiply and record write-back. the next sample is
// accepted right after write-back, so samples do not overlap in the block.
// results go into a 2-entry output queue; when out_ch stalls and the queue
// cannot take a sample's regions, write-back waits and in_ch.ready stays low.
// reset clears the ratios, the queue and the per-channel valid bits; a channel
// without its valid bit reads as a fresh channel, so no clearing pass is needed.
`include "sign_region_peak_detector_top_assert.svh"

module sign_region_peak_detector_top (
  input  logic                          clk,
  input  logic                          rst_n,
  srpd_in_if.sink                       in_ch,
  srpd_out_if.source                    out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [srpd_pkg::CFG_AW-1:0]   paddr,
  input  logic [srpd_pkg::CFG_DW-1:0]   pwdata,
  output logic [srpd_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CALC = 2'd1;
  localparam logic [1:0] ST_MUL  = 2'd2;

  localparam int CH  = srpd_pkg::CHANNELS;
  localparam int SW  = srpd_pkg::SAMPLE_BITS;
  localparam int OW  = srpd_pkg::OFF_W;

  // configuration
  logic [srpd_pkg::RATIO_W-1:0] tol_r;
  logic [srpd_pkg::RATIO_W-1:0] abs_r;
  logic                         cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= '0;
      abs_r <= '0;
    end else if (cfg_we) begin
      if (paddr[2] == srpd_pkg::REG_TOL) begin
        tol_r <= pwdata[srpd_pkg::RATIO_W-1:0];
      end else begin
        abs_r <= pwdata[srpd_pkg::RATIO_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == srpd_pkg::REG_TOL) begin
      prdata = srpd_pkg::CFG_DW'(tol_r);
    end else begin
      prdata = srpd_pkg::CFG_DW'(abs_r);
    end
  end

  // control
  logic [1:0]                st_r, st_nxt;
  logic                      in_acc;
  logic [srpd_pkg::CH_W-1:0] ch_r;
  logic signed [SW-1:0]      smp_r;
  logic                      eos_r;

  // record memory and valid bits
  srpd_pkg::rec_t            rec_mem [CH];
  srpd_pkg::rec_t            mem_q_r;
  logic [CH-1:0]             vld_r;
  logic                      mem_we;

  // calc stage
  srpd_pkg::rec_t            rec;
  srpd_pkg::rec_t            nrec;
  logic                      started;
  logic                      ch_ok;
  logic                      change;
  logic [srpd_pkg::SIGN_W-1:0] code;
  logic signed [OW:0]        judged;
  logic signed [OW-1:0]      m;
  logic [srpd_pkg::POS_W-1:0] pos1;
  srpd_pkg::result_t         old_res, eos_res;
  srpd_pkg::result_t         res0, res1;
  logic [1:0]                nres;

  srpd_pkg::rec_t            nrec_r;
  logic                      change_r;
  logic                      ch_ok_r;
  logic [srpd_pkg::SIGN_W-1:0] code_r;
  srpd_pkg::result_t         res0_r, res1_r;
  logic [1:0]                nres_r;

  // mul stage
  logic [OW-1:0]             mag;
  logic signed [OW-1:0]      new_off;
  srpd_pkg::rec_t            wr_rec;
  logic                      room;
  logic                      done;

  // output queue
  srpd_pkg::result_t         q_r [2];
  logic                      head_r;
  logic [1:0]                cnt_r;
  logic [1:0]                push_n;
  logic                      pop;
  logic                      tail;

  assign in_ch.ready = (st_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ch_r    <= in_ch.channel;
      smp_r   <= in_ch.sample;
      eos_r   <= in_ch.end_of_stream;
      mem_q_r <= rec_mem[in_ch.channel];
    end
    if (mem_we) begin
      rec_mem[ch_r] <= wr_rec;
    end
  end

  always_comb begin
    started = vld_r[ch_r];
    ch_ok   = (int'(ch_r) < CH);
    rec     = started ? mem_q_r : srpd_pkg::REC_RESET;
    pos1    = rec.pos + 1'b1;
    judged  = (OW+1)'(smp_r) + (OW+1)'(rec.offset);
    if (judged < 0) begin
      code = srpd_pkg::SIGN_NEG;
    end else if (judged == 0) begin
      code = srpd_pkg::SIGN_ZERO;
    end else begin
      code = srpd_pkg::SIGN_POS;
    end

    old_res = '{
      out_channel: ch_r, region_sign: rec.sign, region_start: rec.start,
      region_end: rec.pos, peak_magnitude: rec.peak, peak_position: rec.peak_pos,
      last_of_run: 1'b0
    };

    nrec   = rec;
    change = 1'b0;
    m      = '0;
    if (!started) begin
      // first sample opens a region at its own sign with no peak yet
      if (smp_r < 0) begin
        nrec.sign = srpd_pkg::SIGN_NEG;
      end else if (smp_r == 0) begin
        nrec.sign = srpd_pkg::SIGN_ZERO;
      end else begin
        nrec.sign = srpd_pkg::SIGN_POS;
      end
      nrec.start    = rec.pos;
      nrec.peak     = '0;
      nrec.peak_pos = rec.pos;
      nrec.offset   = '0;
    end else begin
      if (code != rec.sign) begin
        change        = 1'b1;
        nrec.sign     = code;
        nrec.start    = rec.pos;
        nrec.peak     = '0;
        nrec.peak_pos = rec.pos;
      end
      unique case (nrec.sign)
        srpd_pkg::SIGN_POS:  m = OW'(smp_r);
        srpd_pkg::SIGN_NEG:  m = -OW'(smp_r);
        default:             m = '0;
      endcase
      if (m > $signed({1'b0, nrec.peak})) begin
        nrec.peak     = m[srpd_pkg::PEAK_W-1:0];
        nrec.peak_pos = rec.pos;
      end
    end
    nrec.pos = pos1;

    eos_res = '{
      out_channel: ch_r, region_sign: nrec.sign, region_start: nrec.start,
      region_end: pos1, peak_magnitude: nrec.peak, peak_position: nrec.peak_pos,
      last_of_run: 1'b0
    };

    res1 = eos_res;
    if (change) begin
      res0 = old_res;
      nres = eos_r ? 2'd2 : 2'd1;
    end else begin
      res0 = eos_res;
      nres = eos_r ? 2'd1 : 2'd0;
    end
    if (!ch_ok) begin
      nres = 2'd0;
    end
    res0.last_of_run = (nres == 2'd1);
    res1.last_of_run = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (st_r == ST_CALC) begin
      nrec_r   <= nrec;
      change_r <= change;
      ch_ok_r  <= ch_ok;
      code_r   <= code;
      res0_r   <= res0;
      res1_r   <= res1;
      nres_r   <= nres;
    end
  end

  srpd_offset u_offset (
    .clk       (clk),
    .load      (st_r == ST_CALC),
    .tol       (tol_r),
    .abs_ratio (abs_r),
    .peak      (mem_q_r.peak),
    .mag       (mag)
  );

  always_comb begin
    unique case (code_r)
      srpd_pkg::SIGN_POS: new_off = $signed(mag);
      srpd_pkg::SIGN_NEG: new_off = -$signed(mag);
      default:            new_off = '0;
    endcase
    wr_rec = nrec_r;
    if (change_r) begin
      wr_rec.offset = new_off;
    end
  end

  assign room   = ((2'd2 - cnt_r) >= nres_r);
  assign done   = (st_r == ST_MUL) && room;
  assign mem_we = done && ch_ok_r;
  assign push_n = done ? nres_r : 2'd0;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (in_acc) st_nxt = ST_CALC;
      ST_CALC: st_nxt = ST_MUL;
      ST_MUL:  if (room) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_IDLE;
      vld_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (mem_we) begin
        // end of stream returns the channel to its reset state
        vld_r[ch_r] <= !eos_r;
      end
    end
  end

  // output queue
  assign pop  = out_ch.valid && out_ch.ready;
  assign tail = head_r ^ cnt_r[0];

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      q_r[tail] <= res0_r;
    end
    if (push_n == 2'd2) begin
      q_r[!tail] <= res1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (pop) begin
        head_r <= !head_r;
      end
      cnt_r <= cnt_r - {1'b0, pop} + push_n;
    end
  end

  assign out_ch.valid          = (cnt_r != 2'd0);
  assign out_ch.out_channel    = q_r[head_r].out_channel;
  assign out_ch.region_sign    = q_r[head_r].region_sign;
  assign out_ch.region_start   = q_r[head_r].region_start;
  assign out_ch.region_end     = q_r[head_r].region_end;
  assign out_ch.peak_magnitude = q_r[head_r].peak_magnitude;
  assign out_ch.peak_position  = q_r[head_r].peak_position;
  assign out_ch.last_of_run    = q_r[head_r].last_of_run;

  `SRPD_ASSERT_NXT(a_acc_to_calc, in_acc, st_r == ST_CALC, "accepted sample did not enter calc")
  `SRPD_ASSERT_IMP(a_queue_room, push_n != 2'd0,
                   ({1'b0, cnt_r} + {1'b0, push_n}) <= 3'd2, "output queue overflow")
  `SRPD_ASSERT_NXT(a_eos_clears, mem_we && eos_r, !vld_r[$past(ch_r)],
                   "end of stream left channel valid")

endmodule
